// File: rtl/core/ehte_pkg.sv
package ehte_pkg;

	// Field and register widths
	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned RUN_W     = 16;
	localparam int unsigned WIN_W     = 13;
	localparam int unsigned SEED_W    = 11;
	localparam int unsigned IDX_W     = 10;
	localparam int unsigned BUDGET_W  = 24;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 24;
	localparam int unsigned OUT_W     = 16;

	// Clamp limits for the window and seed length
	localparam logic [WIN_W-1:0]  MAX_WINDOW    = 13'd4096;
	localparam logic [SEED_W-1:0] MAX_SEED_BITS = 11'd1024;
	localparam logic [SEED_W-1:0] MIN_SEED_BITS = 11'd8;

	// Register reset values
	localparam logic [RUN_W-1:0]    RST_REPEAT_CUTOFF = 16'd32;
	localparam logic [WIN_W-1:0]    RST_WINDOW_LENGTH = 13'd1024;
	localparam logic [WIN_W-1:0]    RST_MIN_ONES      = 13'd410;
	localparam logic [WIN_W-1:0]    RST_MAX_ONES      = 13'd614;
	localparam logic [SEED_W-1:0]   RST_SEED_LENGTH   = 11'd256;
	localparam logic [BUDGET_W-1:0] RST_RAW_BUDGET    = 24'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REPEAT_CUTOFF = 3'd0,
		REG_WINDOW_LENGTH = 3'd1,
		REG_MIN_ONES      = 3'd2,
		REG_MAX_ONES      = 3'd3,
		REG_SEED_LENGTH   = 3'd4,
		REG_RAW_BUDGET    = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_REP_FAIL = 3'd1,
		ST_PROP_FAIL = 3'd2,
		ST_BUDGET   = 3'd3,
		ST_HALTED   = 3'd4,
		ST_FAULT    = 3'd5
	} status_t;

	typedef struct packed {
		status_t          status;
		logic             seed_done;
		logic [IDX_W-1:0] seed_bit_index;
		logic             bit_valid;
		logic             extracted_bit;
	} result_t;

endpackage

// File: rtl/core/entropy_health_test_extractor_unit.sv
// Entropy health tests and von Neumann extractor for one seed.
//
// Input stream (s_*): one raw noise sample per transaction; only s_tdata[0]
// is used. s_tuser carries source_fault (bit 0) and restart (bit 1). A restart
// clears all health and collection state before its own sample is used.
// Output stream (m_*): exactly one result transaction per input transaction,
// carrying the extracted bit, its MSB-first seed index, seed_done and a status
// code. Any failure latches a halt until restart; seed bits delivered since the
// last seed_done must then be discarded by the consumer.
// m_tvalid rises in the cycle after input acceptance. Throughput: one
// transaction per cycle without stalls; all tests, pairing and counters
// update in a single pass of logic into the state and result registers.
// When the receiver stalls, the result register holds and s_tready drops, so
// input stalls only while a result waits and no slot is free.
// Reset: configuration returns to its defaults, all collection state clears
// and no result is pending. Configuration writes on cfg_* take effect at once
// and are meant to be made only while the stream is idle.
module entropy_health_test_extractor_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ehte_pkg::SAMPLE_W-1:0]   s_tdata,  // [15:0] raw_sample
	input  logic [1:0]                      s_tuser,  // [0] source_fault, [1] restart
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] extracted_bit, [1] bit_valid, [11:2] seed_bit_index, [12] seed_done,
	// [15:13] status
	output logic [ehte_pkg::OUT_W-1:0]      m_tdata,
	input  logic                            cfg_wr_en,
	input  logic [ehte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ehte_pkg::CFG_W-1:0]      cfg_data
);
	import ehte_pkg::*;

	// Configuration registers
	logic [RUN_W-1:0]    repeat_cutoff_q;
	logic [WIN_W-1:0]    window_length_q;
	logic [WIN_W-1:0]    min_ones_q;
	logic [WIN_W-1:0]    max_ones_q;
	logic [SEED_W-1:0]   seed_length_q;
	logic [BUDGET_W-1:0] raw_budget_q;

	// Collection state
	logic                prev_bit_q, prev_known_q;
	logic [RUN_W-1:0]    run_len_q;
	logic [WIN_W-1:0]    win_count_q, win_ones_q;
	logic                pair_second_q, first_bit_q;
	logic [BUDGET_W-1:0] raw_used_q;
	logic [SEED_W-1:0]   bits_out_q;
	logic                halted_q;

	// Effective state after an optional restart, and next state
	logic                e_prev_bit, e_prev_known, e_pair_second, e_first_bit, e_halted;
	logic [RUN_W-1:0]    e_run_len;
	logic [WIN_W-1:0]    e_win_count, e_win_ones;
	logic [BUDGET_W-1:0] e_raw_used;
	logic [SEED_W-1:0]   e_bits_out;

	logic                n_prev_bit, n_prev_known, n_pair_second, n_first_bit, n_halted;
	logic [RUN_W-1:0]    n_run_len;
	logic [WIN_W-1:0]    n_win_count, n_win_ones;
	logic [BUDGET_W-1:0] n_raw_used;
	logic [SEED_W-1:0]   n_bits_out;

	logic                in_bit, in_fault, in_restart, s_acc;
	logic [WIN_W-1:0]    win_eff, win_count_inc, win_ones_inc;
	logic [SEED_W-1:0]   seed_target, bits_inc;
	logic                budget_low, rct_fail, apt_fail;
	result_t             res_nx, res_q;

	assign in_bit     = s_tdata[0];
	assign in_fault   = s_tuser[0];
	assign in_restart = s_tuser[1];

	// Take a new item whenever the result slot is empty or being drained
	assign s_tready = !m_tvalid || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tdata  = res_q;

	// Clamp the window to [1, MAX_WINDOW] and the seed to [8, MAX_SEED_BITS]
	always_comb begin
		if (window_length_q == '0) begin
			win_eff = WIN_W'(1);
		end else if (window_length_q > MAX_WINDOW) begin
			win_eff = MAX_WINDOW;
		end else begin
			win_eff = window_length_q;
		end
		if (seed_length_q < MIN_SEED_BITS) begin
			seed_target = MIN_SEED_BITS;
		end else if (seed_length_q > MAX_SEED_BITS) begin
			seed_target = MAX_SEED_BITS;
		end else begin
			seed_target = seed_length_q;
		end
	end

	// Restart clears collection state ahead of this sample
	assign e_prev_bit    = in_restart ? 1'b0 : prev_bit_q;
	assign e_prev_known  = in_restart ? 1'b0 : prev_known_q;
	assign e_run_len     = in_restart ? '0   : run_len_q;
	assign e_win_count   = in_restart ? '0   : win_count_q;
	assign e_win_ones    = in_restart ? '0   : win_ones_q;
	assign e_pair_second = in_restart ? 1'b0 : pair_second_q;
	assign e_first_bit   = in_restart ? 1'b0 : first_bit_q;
	assign e_raw_used    = in_restart ? '0   : raw_used_q;
	assign e_bits_out    = in_restart ? '0   : bits_out_q;
	assign e_halted      = in_restart ? 1'b0 : halted_q;

	assign budget_low    = ({1'b0, e_raw_used} + (BUDGET_W+1)'(2)) > {1'b0, raw_budget_q};
	assign win_count_inc = e_win_count + WIN_W'(1);
	assign win_ones_inc  = e_win_ones + WIN_W'(in_bit);
	assign bits_inc      = e_bits_out + SEED_W'(1);

	always_comb begin
		n_prev_bit    = e_prev_bit;
		n_prev_known  = e_prev_known;
		n_run_len     = e_run_len;
		n_win_count   = e_win_count;
		n_win_ones    = e_win_ones;
		n_pair_second = e_pair_second;
		n_first_bit   = e_first_bit;
		n_raw_used    = e_raw_used;
		n_bits_out    = e_bits_out;
		n_halted      = e_halted;
		rct_fail      = 1'b0;
		apt_fail      = 1'b0;
		res_nx        = '0;
		res_nx.status = ST_OK;

		priority if (e_halted) begin
			// Ignore the sample, hold every counter
			res_nx.status = ST_HALTED;
		end else if (!e_pair_second && budget_low) begin
			n_halted      = 1'b1;
			res_nx.status = ST_BUDGET;
		end else if (in_fault) begin
			n_halted      = 1'b1;
			res_nx.status = ST_FAULT;
		end else begin
			// Repetition count test with a saturating run counter
			if (!e_prev_known) begin
				n_prev_bit   = in_bit;
				n_run_len    = RUN_W'(1);
				n_prev_known = 1'b1;
			end else if (in_bit == e_prev_bit) begin
				n_run_len = (&e_run_len) ? e_run_len : e_run_len + RUN_W'(1);
				rct_fail  = n_run_len > repeat_cutoff_q;
			end else begin
				n_prev_bit = in_bit;
				n_run_len  = RUN_W'(1);
			end

			if (rct_fail) begin
				n_halted      = 1'b1;
				res_nx.status = ST_REP_FAIL;
			end else begin
				// Adaptive proportion test; a failed window keeps its counts
				n_win_count = win_count_inc;
				n_win_ones  = win_ones_inc;
				if (win_count_inc >= win_eff) begin
					apt_fail = (win_ones_inc < min_ones_q) || (win_ones_inc > max_ones_q);
					if (!apt_fail) begin
						n_win_count = '0;
						n_win_ones  = '0;
					end
				end
				if (apt_fail) begin
					n_halted      = 1'b1;
					res_nx.status = ST_PROP_FAIL;
				end else if (!e_pair_second) begin
					n_first_bit   = in_bit;
					n_pair_second = 1'b1;
				end else begin
					// Second bit of a pair: drop 00/11, emit first bit otherwise
					n_pair_second = 1'b0;
					n_raw_used    = e_raw_used + BUDGET_W'(2);
					if (e_first_bit != in_bit) begin
						res_nx.extracted_bit  = e_first_bit;
						res_nx.bit_valid      = 1'b1;
						res_nx.seed_bit_index = e_bits_out[IDX_W-1:0];
						n_bits_out            = bits_inc;
						if (bits_inc >= seed_target) begin
							// Seed complete: start the next one from scratch
							res_nx.seed_done = 1'b1;
							n_prev_bit       = 1'b0;
							n_prev_known     = 1'b0;
							n_run_len        = '0;
							n_win_count      = '0;
							n_win_ones       = '0;
							n_pair_second    = 1'b0;
							n_first_bit      = 1'b0;
							n_raw_used       = '0;
							n_bits_out       = '0;
							n_halted         = 1'b0;
						end
					end
				end
			end
		end
	end

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_cutoff_q <= RST_REPEAT_CUTOFF;
			window_length_q <= RST_WINDOW_LENGTH;
			min_ones_q      <= RST_MIN_ONES;
			max_ones_q      <= RST_MAX_ONES;
			seed_length_q   <= RST_SEED_LENGTH;
			raw_budget_q    <= RST_RAW_BUDGET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_REPEAT_CUTOFF: repeat_cutoff_q <= cfg_data[RUN_W-1:0];
				REG_WINDOW_LENGTH: window_length_q <= cfg_data[WIN_W-1:0];
				REG_MIN_ONES:      min_ones_q      <= cfg_data[WIN_W-1:0];
				REG_MAX_ONES:      max_ones_q      <= cfg_data[WIN_W-1:0];
				REG_SEED_LENGTH:   seed_length_q   <= cfg_data[SEED_W-1:0];
				REG_RAW_BUDGET:    raw_budget_q    <= cfg_data[BUDGET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Advance collection state on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_bit_q    <= 1'b0;
			prev_known_q  <= 1'b0;
			run_len_q     <= '0;
			win_count_q   <= '0;
			win_ones_q    <= '0;
			pair_second_q <= 1'b0;
			first_bit_q   <= 1'b0;
			raw_used_q    <= '0;
			bits_out_q    <= '0;
			halted_q      <= 1'b0;
		end else if (s_acc) begin
			prev_bit_q    <= n_prev_bit;
			prev_known_q  <= n_prev_known;
			run_len_q     <= n_run_len;
			win_count_q   <= n_win_count;
			win_ones_q    <= n_win_ones;
			pair_second_q <= n_pair_second;
			first_bit_q   <= n_first_bit;
			raw_used_q    <= n_raw_used;
			bits_out_q    <= n_bits_out;
			halted_q      <= n_halted;
		end
	end

	// Result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_tready) begin
			m_tvalid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			res_q <= res_nx;
		end
	end

	a_done_has_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.seed_done) |-> res_q.bit_valid)
		else $error("seed_done without a valid bit");

	a_halt_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && halted_q && !in_restart) |=> (res_q.status == ST_HALTED))
		else $error("halted block did not report halted status");

	a_fail_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && res_nx.status != ST_OK) |=> halted_q)
		else $error("failure did not latch a halt");

	a_pair_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && res_nx.bit_valid) |=> !pair_second_q)
		else $error("pair still open after an extracted bit");

endmodule

// File: sim/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ehte_pkg::*;

	// Random phases of about eighty counted samples each; the last one is preceded by
	// the long repetition run and runs without any idling.
	localparam int unsigned RAND_PHASES    = 17;
	localparam int unsigned PHASE_SAMPLES  = 80;
	localparam int unsigned PRESSURE_PHASE = 7;
	localparam int unsigned HOLD_CYCLES    = 300;
	// Equal bits in the long run; enough to complete several windows of ones.
	localparam int unsigned LONG_RUN       = 200;
	localparam int unsigned CYCLE_LIMIT    = 2000000;
	localparam int unsigned DRAIN_LIMIT    = 5000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [SAMPLE_W-1:0]  s_tdata   = '0;
	logic [1:0]           s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b1;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_REPEAT_CUTOFF;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Shared flags between the stimulus, the receiver and the end of the run.
	logic        no_idle  = 1'b0;
	logic        hold_req = 1'b0;
	int unsigned mismatch_cnt = 0;
	int unsigned n_samples = 0, n_long = 0, n_checked = 0, n_bits = 0, n_seeds = 0;
	int unsigned status_seen [0:7];

	// Expected extractor results, oldest first.
	result_t extract_q [$];

	// Predictor copy of the health and collection state.
	logic              p_prev_bit, p_prev_known, p_pair_open, p_pair_first, p_halted;
	logic [RUN_W-1:0]  p_run;
	logic [WIN_W-1:0]  p_win_cnt, p_win_ones;
	logic [BUDGET_W-1:0] p_raw_used;
	logic [SEED_W-1:0] p_bits_out;

	// Predictor copy of the registers.
	logic [RUN_W-1:0]    c_cutoff;
	logic [WIN_W-1:0]    c_window, c_min_ones, c_max_ones;
	logic [SEED_W-1:0]   c_seed_len;
	logic [BUDGET_W-1:0] c_budget;

	// One row of the directed table: either a register write or a sample, the latter with
	// an optional hand-written expectation.
	typedef struct {
		logic                is_write;
		cfg_reg_t            reg_sel;
		logic [CFG_W-1:0]    value;
		logic [SAMPLE_W-1:0] smp;
		logic                flt;
		logic                rst;
		logic                typed;
		result_t             want;
	} stim_row_t;

	stim_row_t stim_rows [$];

	entropy_health_test_extractor_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin : clock_gen
		forever #6 clk = ~clk;
	end

	function automatic result_t res_of(logic ext, logic valid, int unsigned idx, logic done,
			status_t st);
		result_t r;
		r = '0;
		r.extracted_bit  = ext;
		r.bit_valid      = valid;
		r.seed_bit_index = idx[IDX_W-1:0];
		r.seed_done      = done;
		r.status         = st;
		return r;
	endfunction

	function automatic stim_row_t row_write(cfg_reg_t r, int unsigned v);
		stim_row_t row;
		row          = '{default: '0, reg_sel: REG_REPEAT_CUTOFF, want: '0};
		row.is_write = 1'b1;
		row.reg_sel  = r;
		row.value    = v[CFG_W-1:0];
		return row;
	endfunction

	function automatic stim_row_t row_item(logic [SAMPLE_W-1:0] smp, logic flt, logic rst,
			logic typed, result_t want);
		stim_row_t row;
		row       = '{default: '0, reg_sel: REG_REPEAT_CUTOFF, want: '0};
		row.smp   = smp;
		row.flt   = flt;
		row.rst   = rst;
		row.typed = typed;
		row.want  = want;
		return row;
	endfunction

	// Drop every piece of health and collection state; registers stay.
	task automatic clear_seed_state();
		p_prev_bit   = 1'b0;
		p_prev_known = 1'b0;
		p_run        = '0;
		p_win_cnt    = '0;
		p_win_ones   = '0;
		p_pair_open  = 1'b0;
		p_pair_first = 1'b0;
		p_raw_used   = '0;
		p_bits_out   = '0;
		p_halted     = 1'b0;
	endtask

	// Work out the result of one accepted sample and advance the predictor state.
	task automatic predict_extract(input logic [SAMPLE_W-1:0] smp, input logic flt,
			input logic rst, output result_t r);
		logic        b;
		int unsigned win, tgt;
		status_t     st;
		b = smp[0];
		r = res_of(1'b0, 1'b0, 0, 1'b0, ST_OK);
		if (rst)
			clear_seed_state();
		if (p_halted) begin
			r.status = ST_HALTED;
		end else if (!p_pair_open && p_raw_used + 2 > c_budget) begin
			// budget is checked only ahead of the first bit of a pair
			p_halted = 1'b1;
			r.status = ST_BUDGET;
		end else if (flt) begin
			p_halted = 1'b1;
			r.status = ST_FAULT;
		end else begin
			st = ST_OK;
			// repetition count: saturating run counter
			if (!p_prev_known) begin
				p_prev_bit   = b;
				p_run        = RUN_W'(1);
				p_prev_known = 1'b1;
			end else if (b == p_prev_bit) begin
				if (p_run != '1)
					p_run = p_run + 1'b1;
				if (p_run > c_cutoff)
					st = ST_REP_FAIL;
			end else begin
				p_prev_bit = b;
				p_run      = RUN_W'(1);
			end
			// adaptive proportion: skipped when the repetition test already failed
			if (st == ST_OK) begin
				win = c_window;
				if (win == 0)
					win = 1;
				if (win > MAX_WINDOW)
					win = MAX_WINDOW;
				p_win_cnt  = p_win_cnt + 1'b1;
				p_win_ones = p_win_ones + b;
				if (p_win_cnt >= win) begin
					if (p_win_ones < c_min_ones || p_win_ones > c_max_ones) begin
						st = ST_PROP_FAIL;
					end else begin
						p_win_cnt  = '0;
						p_win_ones = '0;
					end
				end
			end
			r.status = st;
			if (st != ST_OK) begin
				p_halted = 1'b1;
			end else if (!p_pair_open) begin
				p_pair_first = b;
				p_pair_open  = 1'b1;
			end else begin
				p_pair_open = 1'b0;
				p_raw_used  = p_raw_used + 2'd2;
				if (p_pair_first != b) begin
					tgt = c_seed_len;
					if (tgt < MIN_SEED_BITS)
						tgt = MIN_SEED_BITS;
					if (tgt > MAX_SEED_BITS)
						tgt = MAX_SEED_BITS;
					r.extracted_bit  = p_pair_first;
					r.bit_valid      = 1'b1;
					r.seed_bit_index = p_bits_out[IDX_W-1:0];
					p_bits_out       = p_bits_out + 1'b1;
					if (p_bits_out >= tgt) begin
						r.seed_done = 1'b1;
						clear_seed_state();
					end
				end
			end
		end
	endtask

	// Offer one sample, hold it until the block takes it, then queue its expected result.
	task automatic offer_sample(input logic [SAMPLE_W-1:0] smp, input logic flt,
			input logic rst, input logic typed, input result_t want, output status_t st);
		result_t r;
		cfg_wr_en <= 1'b0;
		if (!no_idle && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= {rst, flt};
		do @(posedge clk); while (!s_tready);
		predict_extract(smp, flt, rst, r);
		if (typed)
			r = want;
		extract_q.push_back(r);
		n_samples++;
		status_seen[r.status]++;
		if (r.bit_valid)
			n_bits++;
		if (r.seed_done)
			n_seeds++;
		st = r.status;
	endtask

	// Stop offering and let every outstanding result drain before touching a register.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (extract_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write one register; the caller keeps the stream idle.
	task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(posedge clk);
		case (r)
			REG_REPEAT_CUTOFF: c_cutoff   = v[RUN_W-1:0];
			REG_WINDOW_LENGTH: c_window   = v[WIN_W-1:0];
			REG_MIN_ONES:      c_min_ones = v[WIN_W-1:0];
			REG_MAX_ONES:      c_max_ones = v[WIN_W-1:0];
			REG_SEED_LENGTH:   c_seed_len = v[SEED_W-1:0];
			REG_RAW_BUDGET:    c_budget   = v[BUDGET_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_cfg(input int unsigned cut, input int unsigned win,
			input int unsigned lo, input int unsigned hi, input int unsigned seed,
			input int unsigned bud);
		quiesce();
		write_reg(REG_REPEAT_CUTOFF, cut[CFG_W-1:0]);
		write_reg(REG_WINDOW_LENGTH, win[CFG_W-1:0]);
		write_reg(REG_MIN_ONES, lo[CFG_W-1:0]);
		write_reg(REG_MAX_ONES, hi[CFG_W-1:0]);
		write_reg(REG_SEED_LENGTH, seed[CFG_W-1:0]);
		write_reg(REG_RAW_BUDGET, bud[CFG_W-1:0]);
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request so the result
	// register fills and the block has to drop s_tready.
	initial begin : result_sink
		int unsigned n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				m_tready <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 11) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Compare every result transaction against the oldest expectation.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			n_checked++;
			if (extract_q.size() == 0) begin
				mismatch_cnt++;
				$display("%0t ns: unexpected result, expected none, actual %h",
					$time, m_tdata);
			end else begin
				want = extract_q.pop_front();
				if (got.extracted_bit !== want.extracted_bit
						|| got.bit_valid !== want.bit_valid
						|| got.seed_bit_index !== want.seed_bit_index
						|| got.seed_done !== want.seed_done
						|| got.status !== want.status) begin
					mismatch_cnt++;
					$display({"%0t ns: result %0d expected bit=%0b valid=%0b idx=%0d ",
						"done=%0b status=%0d, actual bit=%0b valid=%0b idx=%0d ",
						"done=%0b status=%0d"}, $time, n_checked,
						want.extracted_bit, want.bit_valid, want.seed_bit_index,
						want.seed_done, want.status, got.extracted_bit, got.bit_valid,
						got.seed_bit_index, got.seed_done, got.status);
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d results still expected", cycles,
			extract_q.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int unsigned ph, counted, i, k, win_eff, cut, win, lo, hi, seed, bud;
		logic [31:0] r32;
		logic        b, last_b, flt, rst, sticky, prev_write;
		status_t     st;
		result_t     left;

		foreach (status_seen[j])
			status_seen[j] = 0;
		c_cutoff   = RST_REPEAT_CUTOFF;
		c_window   = RST_WINDOW_LENGTH;
		c_min_ones = RST_MIN_ONES;
		c_max_ones = RST_MAX_ONES;
		c_seed_len = RST_SEED_LENGTH;
		c_budget   = RST_RAW_BUDGET;
		clear_seed_state();
		last_b = 1'b0;

		// Directed table. Default registers after reset: pairing, both mappings, dropped
		// equal pairs, source fault, halt, restart, then each failure code in turn.
		stim_rows.push_back(row_item(16'hFFFF, 0, 0, 1, res_of(0, 0, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h0000, 0, 0, 1, res_of(1, 1, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h0001, 0, 0, 1, res_of(0, 0, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'hFFFE, 0, 0, 1, res_of(1, 1, 1, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h0000, 0, 0, 1, res_of(0, 0, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h0001, 0, 0, 1, res_of(0, 1, 2, 0, ST_OK)));
		// equal pairs give nothing
		stim_rows.push_back(row_item(16'h8001, 0, 0, 1, res_of(0, 0, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h7FFF, 0, 0, 1, res_of(0, 0, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h0000, 0, 0, 1, res_of(0, 0, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h0000, 0, 0, 1, res_of(0, 0, 0, 0, ST_OK)));
		// fault halts; a halted block ignores even a second fault
		stim_rows.push_back(row_item(16'h0000, 1, 0, 1, res_of(0, 0, 0, 0, ST_FAULT)));
		stim_rows.push_back(row_item(16'h0001, 0, 0, 1, res_of(0, 0, 0, 0, ST_HALTED)));
		stim_rows.push_back(row_item(16'h0001, 0, 1, 1, res_of(0, 0, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h0000, 1, 1, 1, res_of(0, 0, 0, 0, ST_FAULT)));
		stim_rows.push_back(row_item(16'h0000, 1, 0, 1, res_of(0, 0, 0, 0, ST_HALTED)));
		stim_rows.push_back(row_item(16'h0000, 0, 1, 1, res_of(0, 0, 0, 0, ST_OK)));
		// repetition fail on the second equal bit
		stim_rows.push_back(row_write(REG_REPEAT_CUTOFF, 1));
		stim_rows.push_back(row_item(16'h0001, 0, 1, 1, res_of(0, 0, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h0001, 0, 0, 1, res_of(0, 0, 0, 0, ST_REP_FAIL)));
		// one-bit window that allows no ones
		stim_rows.push_back(row_write(REG_REPEAT_CUTOFF, 32));
		stim_rows.push_back(row_write(REG_WINDOW_LENGTH, 1));
		stim_rows.push_back(row_write(REG_MIN_ONES, 0));
		stim_rows.push_back(row_write(REG_MAX_ONES, 0));
		stim_rows.push_back(row_item(16'h0000, 0, 1, 1, res_of(0, 0, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h0001, 0, 0, 1, res_of(0, 0, 0, 0, ST_PROP_FAIL)));
		// budget of zero fails at once; budget of two allows exactly one pair
		stim_rows.push_back(row_write(REG_WINDOW_LENGTH, 1024));
		stim_rows.push_back(row_write(REG_MIN_ONES, 410));
		stim_rows.push_back(row_write(REG_MAX_ONES, 614));
		stim_rows.push_back(row_write(REG_RAW_BUDGET, 0));
		stim_rows.push_back(row_item(16'h0000, 0, 1, 1, res_of(0, 0, 0, 0, ST_BUDGET)));
		stim_rows.push_back(row_write(REG_RAW_BUDGET, 2));
		stim_rows.push_back(row_item(16'h0001, 0, 1, 1, res_of(0, 0, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h0000, 0, 0, 1, res_of(1, 1, 0, 0, ST_OK)));
		stim_rows.push_back(row_item(16'h0001, 0, 0, 1, res_of(0, 0, 0, 0, ST_BUDGET)));
		stim_rows.push_back(row_item(16'hFFFF, 0, 1, 0, '0));

		// Hold reset, then release it on a rising edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; drain before the first write of each group.
		prev_write = 1'b0;
		for (i = 0; i < stim_rows.size(); i++) begin
			if (stim_rows[i].is_write) begin
				if (!prev_write)
					quiesce();
				write_reg(stim_rows[i].reg_sel, stim_rows[i].value);
			end else begin
				offer_sample(stim_rows[i].smp, stim_rows[i].flt, stim_rows[i].rst,
					stim_rows[i].typed, stim_rows[i].want, st);
			end
			prev_write = stim_rows[i].is_write;
		end

		// Random phases: fixed corner settings first, random settings after.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: apply_cfg(65534, 4096, 0, 4096, 1024, 24'hFFFFFF);
				1: apply_cfg(1, 1, 0, 1, 0, 2);
				2: apply_cfg(3, 0, 0, 1, 7, 0);
				3: apply_cfg(40, 8191, 0, 4096, 2047, 1);
				4: apply_cfg(65535, 16, 4, 12, 12, 300);
				default: begin
					case ($urandom_range(0, 5))
						0: cut = $urandom_range(1, 3);
						4: cut = 65534;
						5: cut = 65535;
						default: cut = $urandom_range(4, 24);
					endcase
					case ($urandom_range(0, 5))
						0: win = $urandom_range(0, 2);
						4: win = 4096;
						5: win = $urandom_range(4097, 8191);
						default: win = $urandom_range(3, 64);
					endcase
					win_eff = (win == 0) ? 1 : (win > MAX_WINDOW) ? MAX_WINDOW : win;
					case ($urandom_range(0, 4))
						3: begin
							lo = win_eff / 2;
							hi = win_eff / 2;
						end
						4: begin
							lo = $urandom_range(0, 4096);
							hi = $urandom_range(0, 4096);
						end
						default: begin
							lo = win_eff / 8;
							hi = win_eff - win_eff / 8;
						end
					endcase
					case ($urandom_range(0, 5))
						0: seed = $urandom_range(0, 7);
						3: seed = $urandom_range(25, 120);
						4: seed = $urandom_range(1, 16) * 8;
						5: seed = $urandom_range(1024, 2047);
						default: seed = $urandom_range(8, 24);
					endcase
					case ($urandom_range(0, 5))
						0: bud = $urandom_range(0, 3);
						1: bud = $urandom_range(4, 64);
						5: bud = 24'hFFFFFF;
						default: bud = $urandom_range(65, 5000);
					endcase
					apply_cfg(cut, win, lo, hi, seed, bud);
				end
			endcase

			if (ph == PRESSURE_PHASE)
				hold_req = 1'b1;

			// Before the last phase: a long run of equal ones with the cutoff at its top
			// value so it never trips. The window allows every count, so each full window
			// of ones sits right at the upper bound.
			if (ph == RAND_PHASES - 1) begin
				no_idle = 1'b1;
				apply_cfg(65535, 64, 0, 64, 1024, 24'hFFFFFF);
				for (k = 0; k < LONG_RUN; k++) begin
					r32 = $urandom();
					offer_sample({r32[15:1], 1'b1}, 1'b0, k == 0, 1'b0, '0, st);
				end
				n_long = LONG_RUN;
				apply_cfg(cut, win, lo, hi, seed, bud);
			end

			// Mostly clean streams, some phases biased toward long runs; restart out of a
			// halt fairly soon so the phase keeps reaching the pairing logic.
			sticky  = ($urandom_range(0, 3) == 0);
			counted = 0;
			while (counted < PHASE_SAMPLES) begin
				r32 = $urandom();
				if (p_halted) begin
					rst = ($urandom_range(0, 2) == 0);
					flt = r32[20];
				end else begin
					rst = ($urandom_range(0, 99) == 0);
					flt = ($urandom_range(0, 79) == 0);
				end
				b = (sticky && $urandom_range(0, 7) != 0) ? last_b : r32[0];
				last_b = b;
				offer_sample({r32[15:1], b}, flt, rst, 1'b0, '0, st);
				if (st != ST_HALTED)
					counted++;
			end
		end

		// Let the last results out, then allow time for anything stray.
		s_tvalid <= 1'b0;
		for (k = 0; k < DRAIN_LIMIT && extract_q.size() != 0; k++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (extract_q.size() != 0) begin
			left = extract_q.pop_front();
			mismatch_cnt++;
			$display({"%0t ns: expected bit=%0b valid=%0b idx=%0d done=%0b status=%0d, ",
				"actual none"}, $time, left.extracted_bit, left.bit_valid,
				left.seed_bit_index, left.seed_done, left.status);
		end

		$display("Run: %0d samples (%0d in one long equal run), %0d results, %0d bits, %0d seeds",
			n_samples, n_long, n_checked, n_bits, n_seeds);
		$display("Status mix: ok %0d, rep %0d, prop %0d, budget %0d, halted %0d, fault %0d",
			status_seen[ST_OK], status_seen[ST_REP_FAIL], status_seen[ST_PROP_FAIL],
			status_seen[ST_BUDGET], status_seen[ST_HALTED], status_seen[ST_FAULT]);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
